@@ rtl/hcgb_pkg.sv @@
// Shared types and constants for the hop-count gradient beacon.
`timescale 1ns / 1ps

package hcgb_pkg;

  localparam int unsigned HOP_W     = 8;
  localparam int unsigned AGE_W     = 16;
  localparam int unsigned ID_W      = 16;
  localparam int unsigned BACKOFF_W = 8;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned MSG_W     = 32;

  localparam logic [HOP_W-1:0]     HOP_UNKNOWN    = 8'hFF;
  localparam logic [AGE_W-1:0]     AGE_MAX        = 16'hFFFF;
  localparam logic [BACKOFF_W-1:0] BACKOFF_STEP   = 8'd5;
  localparam logic [ID_W-1:0]      ID_RESET       = 16'd0;
  localparam logic [AGE_W-1:0]     TIMEOUT_RESET  = 16'd10000;
  localparam logic [BACKOFF_W-1:0] BACKOFF_RESET  = 8'd20;

  typedef enum logic [1:0] {
    CMD_TICK      = 2'd0,
    CMD_HEARD     = 2'd1,
    CMD_PASS_END  = 2'd2,
    CMD_ROUND_END = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_ROBOT_ID        = 2'd0,
    REG_TIMEOUT_TICKS   = 2'd1,
    REG_DEFAULT_BACKOFF = 2'd2
  } reg_idx_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [HOP_W-1:0] nest_hops_in;
    logic [HOP_W-1:0] food_hops_in;
    logic             decoded;
    logic             channel_busy;
  } req_t;

endpackage

@@ rtl/hop_count_gradient_beacon.sv @@
// Top level of the hop-count gradient beacon node.
`timescale 1ns / 1ps

// Each request passes the input register, then the state update into the
// result register. A new request is accepted every cycle unless out_ready
// holds back a full result register; node state is read and written in the
// single update stage. The user must write configuration only while the node
// is idle; the block does not enforce it. Every request gives exactly one result.
module hop_count_gradient_beacon (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_nest_hops_in,
  input  logic [7:0]  in_food_hops_in,
  input  logic        in_decoded,
  input  logic        in_channel_busy,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_send_now,
  output logic [31:0] out_message_out,
  output logic [7:0]  out_nest_hops,
  output logic [7:0]  out_food_hops,
  output logic [7:0]  out_backoff,
  output logic        out_keep_listening,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic [hcgb_pkg::ID_W-1:0]      robot_id_r;
  logic [hcgb_pkg::AGE_W-1:0]     timeout_ticks_r;
  logic [hcgb_pkg::BACKOFF_W-1:0] default_backoff_r;

  logic [hcgb_pkg::HOP_W-1:0]     nest_hop_r, nest_hop_nxt;
  logic [hcgb_pkg::HOP_W-1:0]     food_hop_r, food_hop_nxt;
  logic [hcgb_pkg::HOP_W-1:0]     nest_min_r, nest_min_nxt;
  logic [hcgb_pkg::HOP_W-1:0]     food_min_r, food_min_nxt;
  logic [hcgb_pkg::AGE_W-1:0]     nest_age_r, nest_age_nxt;
  logic [hcgb_pkg::AGE_W-1:0]     food_age_r, food_age_nxt;
  logic [hcgb_pkg::BACKOFF_W-1:0] backoff_r, backoff_nxt;
  logic                           heard_r, heard_nxt;

  hcgb_pkg::req_t req_r;
  logic           req_valid_r;
  logic           out_valid_r;
  logic           advance;

  logic                           send_nxt;
  logic                           keep_nxt;
  logic [hcgb_pkg::HOP_W-1:0]     nest_base;
  logic [hcgb_pkg::HOP_W-1:0]     food_base;

  logic        out_send_now_r;
  logic [31:0] out_message_out_r;
  logic [7:0]  out_nest_hops_r;
  logic [7:0]  out_food_hops_r;
  logic [7:0]  out_backoff_r;
  logic        out_keep_listening_r;

  assign advance  = req_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !req_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      robot_id_r        <= hcgb_pkg::ID_RESET;
      timeout_ticks_r   <= hcgb_pkg::TIMEOUT_RESET;
      default_backoff_r <= hcgb_pkg::BACKOFF_RESET;
    end else if (cfg_we) begin
      unique case (hcgb_pkg::reg_idx_t'(cfg_index))
        hcgb_pkg::REG_ROBOT_ID:        robot_id_r        <= cfg_wdata;
        hcgb_pkg::REG_TIMEOUT_TICKS:   timeout_ticks_r   <= cfg_wdata;
        hcgb_pkg::REG_DEFAULT_BACKOFF: default_backoff_r <= cfg_wdata[hcgb_pkg::BACKOFF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_ready) begin
      req_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r.cmd          <= hcgb_pkg::cmd_t'(in_cmd);
      req_r.nest_hops_in <= in_nest_hops_in;
      req_r.food_hops_in <= in_food_hops_in;
      req_r.decoded      <= in_decoded;
      req_r.channel_busy <= in_channel_busy;
    end
  end

  always_comb begin
    nest_hop_nxt = nest_hop_r;
    food_hop_nxt = food_hop_r;
    nest_min_nxt = nest_min_r;
    food_min_nxt = food_min_r;
    nest_age_nxt = nest_age_r;
    food_age_nxt = food_age_r;
    backoff_nxt  = backoff_r;
    heard_nxt    = heard_r;
    send_nxt     = 1'b0;
    keep_nxt     = 1'b0;
    nest_base    = (nest_age_r > timeout_ticks_r) ? hcgb_pkg::HOP_UNKNOWN : nest_hop_r;
    food_base    = (food_age_r > timeout_ticks_r) ? hcgb_pkg::HOP_UNKNOWN : food_hop_r;
    unique case (req_r.cmd)
      hcgb_pkg::CMD_TICK: begin
        if (nest_age_r != hcgb_pkg::AGE_MAX) nest_age_nxt = nest_age_r + 1'b1;
        if (food_age_r != hcgb_pkg::AGE_MAX) food_age_nxt = food_age_r + 1'b1;
      end
      hcgb_pkg::CMD_HEARD: begin
        heard_nxt = 1'b1;
        if (req_r.decoded) begin
          if (req_r.nest_hops_in != '0 && req_r.nest_hops_in < nest_min_r) begin
            nest_min_nxt = req_r.nest_hops_in;
          end
          if (req_r.food_hops_in != '0 && req_r.food_hops_in < food_min_r) begin
            food_min_nxt = req_r.food_hops_in;
          end
        end
      end
      hcgb_pkg::CMD_PASS_END: begin
        // A minimum plus one is adopted when it does not exceed the current count.
        nest_hop_nxt = nest_base;
        food_hop_nxt = food_base;
        if (nest_min_r != hcgb_pkg::HOP_UNKNOWN && nest_min_r < nest_base) begin
          nest_hop_nxt = nest_min_r + 1'b1;
          nest_age_nxt = '0;
        end
        if (food_min_r != hcgb_pkg::HOP_UNKNOWN && food_min_r < food_base) begin
          food_hop_nxt = food_min_r + 1'b1;
          food_age_nxt = '0;
        end
        keep_nxt  = heard_r || (nest_min_r == hcgb_pkg::HOP_UNKNOWN &&
                                food_min_r == hcgb_pkg::HOP_UNKNOWN);
        heard_nxt = 1'b0;
      end
      hcgb_pkg::CMD_ROUND_END: begin
        if (!req_r.channel_busy) begin
          backoff_nxt = default_backoff_r;
          send_nxt    = 1'b1;
        end else if (backoff_r >= hcgb_pkg::BACKOFF_STEP) begin
          backoff_nxt = backoff_r - hcgb_pkg::BACKOFF_STEP;
        end
        nest_min_nxt = hcgb_pkg::HOP_UNKNOWN;
        food_min_nxt = hcgb_pkg::HOP_UNKNOWN;
        heard_nxt    = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nest_hop_r  <= hcgb_pkg::HOP_UNKNOWN;
      food_hop_r  <= hcgb_pkg::HOP_UNKNOWN;
      nest_min_r  <= hcgb_pkg::HOP_UNKNOWN;
      food_min_r  <= hcgb_pkg::HOP_UNKNOWN;
      nest_age_r  <= '0;
      food_age_r  <= '0;
      backoff_r   <= hcgb_pkg::BACKOFF_RESET;
      heard_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        nest_hop_r <= nest_hop_nxt;
        food_hop_r <= food_hop_nxt;
        nest_min_r <= nest_min_nxt;
        food_min_r <= food_min_nxt;
        nest_age_r <= nest_age_nxt;
        food_age_r <= food_age_nxt;
        backoff_r  <= backoff_nxt;
        heard_r    <= heard_nxt;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_send_now_r       <= send_nxt;
      out_message_out_r    <= {robot_id_r, food_hop_nxt, nest_hop_nxt};
      out_nest_hops_r      <= nest_hop_nxt;
      out_food_hops_r      <= food_hop_nxt;
      out_backoff_r        <= backoff_nxt;
      out_keep_listening_r <= keep_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_send_now       = out_send_now_r;
  assign out_message_out    = out_message_out_r;
  assign out_nest_hops      = out_nest_hops_r;
  assign out_food_hops      = out_food_hops_r;
  assign out_backoff        = out_backoff_r;
  assign out_keep_listening = out_keep_listening_r;

  a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (req_valid_r && out_valid_r && !out_ready))
    else $error("input stalled without a full pipeline");

  a_send_excludes_keep: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_send_now_r && out_keep_listening_r))
    else $error("send and keep listening reported together");

  a_min_never_zero: assert property (@(posedge clk) disable iff (!rst_n)
    nest_min_r != '0 && food_min_r != '0)
    else $error("pass minimum reached zero");

  a_send_restores_backoff: assert property (@(posedge clk) disable iff (!rst_n)
    advance && send_nxt |=> out_backoff_r == default_backoff_r)
    else $error("backoff not restored after a send");

endmodule
